/* hw/rtl/rts_pkg.sv */
// record table sort engine: shared types, constants and request codes
// no dependencies
package rts_pkg;
  localparam int unsigned DEPTH = 128;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = 72;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_READ = 3'd2;
  localparam logic [2:0] REQ_SORT_TITLE = 3'd3;
  localparam logic [2:0] REQ_SORT_AUTHOR = 3'd4;
  localparam logic [2:0] REQ_SORT_PRICE = 3'd5;
  localparam logic [2:0] REQ_MAX = 3'd6;
  localparam logic [2:0] REQ_UNDEF = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [15:0] book_id;
    logic [15:0] quantity;
    logic [23:0] price;
    logic [7:0] title_initial;
    logic [7:0] author_initial;
  } rec_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [15:0] book_id;
    logic [15:0] quantity;
    logic [23:0] price_cents;
    logic [7:0] title_initial;
    logic [7:0] author_initial;
    logic [6:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] out_id;
    logic [15:0] out_quantity;
    logic [23:0] out_price;
    logic [7:0] out_title_initial;
    logic [7:0] out_author_initial;
    logic [39:0] total_value;
    logic [7:0] entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0] wr_sel;   // 0 request record, 1 held a, 2 held b
    logic lat_a;
    logic lat_b;
    logic lat_best;
    logic mul_start;
  } cmd_t;

  localparam logic [1:0] WSEL_REQ = 2'd0;
  localparam logic [1:0] WSEL_A = 2'd1;
  localparam logic [1:0] WSEL_B = 2'd2;

  // datapath to controller
  typedef struct packed {
    logic id_match;
    logic a_gt_b;
    logic best_lt_b;
  } sts_t;
endpackage

/* hw/rtl/rts_stream_if.sv */
// valid/ready channel carrying a packed payload
// depends on nothing
interface rts_stream_if #(parameter int unsigned W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rts_ram.sv */
// generic single write, single read ram with registered read
// no dependencies
module rts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

/* hw/rtl/rts_datapath.sv */
// record store, holding registers, key compare and value multiplier
// depends on rts_pkg, rts_ram
module rts_datapath (
  input  logic clk,
  input  rts_pkg::req_t req,
  input  rts_pkg::cmd_t cmd,
  output rts_pkg::sts_t sts,
  output rts_pkg::rec_t best_rec,
  output logic [39:0] product
);
  import rts_pkg::*;
  rec_t rd_rec, a_rec, b_rec, wr_rec;
  logic [23:0] ka, kb;

  always_comb begin
    case (cmd.wr_sel)
      WSEL_A: wr_rec = a_rec;
      WSEL_B: wr_rec = b_rec;
      default: wr_rec = '{req.book_id, req.quantity, req.price_cents,
                          req.title_initial, req.author_initial};
    endcase
  end

  rts_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_store (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_rec),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_rec)
  );

  always_ff @(posedge clk) begin
    if (cmd.lat_a) a_rec <= rd_rec;
    if (cmd.lat_b) b_rec <= rd_rec;
    if (cmd.lat_best) best_rec <= rd_rec;
    if (cmd.mul_start) product <= 40'(best_rec.price * best_rec.quantity);
  end

  always_comb begin
    case (req.req_type)
      REQ_SORT_TITLE: begin
        ka = {16'd0, a_rec.title_initial};
        kb = {16'd0, b_rec.title_initial};
      end
      REQ_SORT_AUTHOR: begin
        ka = {16'd0, a_rec.author_initial};
        kb = {16'd0, b_rec.author_initial};
      end
      default: begin
        ka = a_rec.price;
        kb = b_rec.price;
      end
    endcase
  end

  assign sts.a_gt_b = ka > kb;
  assign sts.id_match = rd_rec.book_id == req.book_id;
  assign sts.best_lt_b = best_rec.price < rd_rec.price;
endmodule

/* hw/rtl/rts_ctrl.sv */
// sequencer for add, remove, read, exchange sort and max search
// depends on rts_pkg
module rts_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rts_pkg::req_t in_data,
  output rts_pkg::req_t req,
  output rts_pkg::cmd_t cmd,
  input  rts_pkg::sts_t sts,
  output logic [rts_pkg::CW-1:0] count,
  output logic done,
  output logic [1:0] status,
  output logic emit,
  input  logic out_busy
);
  import rts_pkg::*;
  localparam logic [4:0] S_IDLE = 5'd0, S_DISPATCH = 5'd1, S_RM_RD = 5'd2,
    S_RM_CHK = 5'd3, S_SH_RD = 5'd4, S_SH_LAT = 5'd5, S_SH_WR = 5'd6,
    S_SO_RA = 5'd7, S_SO_RB = 5'd8, S_SO_LAT = 5'd9, S_SO_CMP = 5'd10,
    S_SO_WB = 5'd11, S_RD_WAIT = 5'd12, S_MX_RD = 5'd13, S_MX_CHK = 5'd14,
    S_MUL = 5'd15, S_DONE = 5'd16;
  logic [4:0] state;
  logic [CW-1:0] i, j;
  logic more_j, more_i;

  assign in_ready = state == S_IDLE;
  assign more_j = (j + 1'b1) < count;
  assign more_i = (i + CW'(2)) < count;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_DISPATCH: begin
        cmd.wr_en = req.req_type == REQ_ADD && count < CW'(DEPTH);
        cmd.wr_addr = count[AW-1:0];
        cmd.wr_sel = WSEL_REQ;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = (req.req_type == REQ_READ) ? req.slot_index[AW-1:0] : '0;
      end
      S_RM_RD, S_MX_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = j[AW-1:0];
      end
      S_SH_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = AW'(j + 1'b1);
      end
      S_SH_LAT: cmd.lat_b = 1'b1;
      S_SH_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_addr = j[AW-1:0];
        cmd.wr_sel = WSEL_B;
      end
      S_SO_RA: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = i[AW-1:0];
      end
      S_SO_RB: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = j[AW-1:0];
        cmd.lat_a = 1'b1;
      end
      S_SO_LAT: cmd.lat_b = 1'b1;
      S_SO_CMP: begin
        cmd.wr_en = sts.a_gt_b;
        cmd.wr_addr = i[AW-1:0];
        cmd.wr_sel = WSEL_B;
      end
      S_SO_WB: begin
        cmd.wr_en = 1'b1;
        cmd.wr_addr = j[AW-1:0];
        cmd.wr_sel = WSEL_A;
      end
      S_RD_WAIT: cmd.lat_best = 1'b1;
      S_MX_CHK: cmd.lat_best = sts.best_lt_b;
      S_MUL: cmd.mul_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
      emit <= 1'b0;
      status <= ST_OK;
      i <= '0;
      j <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          status <= ST_OK;
          emit <= 1'b0;
          i <= '0;
          j <= '0;
          case (req.req_type)
            REQ_ADD: begin
              if (count < CW'(DEPTH)) count <= count + 1'b1;
              else status <= ST_FULL;
              state <= S_DONE;
            end
            REQ_REMOVE: begin
              status <= ST_MISSING;
              state <= (count == '0) ? S_DONE : S_RM_RD;
            end
            REQ_READ: begin
              if (CW'(req.slot_index) >= count) begin
                status <= ST_MISSING;
                state <= S_DONE;
              end else begin
                emit <= 1'b1;
                state <= S_RD_WAIT;
              end
            end
            REQ_SORT_TITLE, REQ_SORT_AUTHOR, REQ_SORT_PRICE: begin
              j <= CW'(1);
              state <= (count < CW'(2)) ? S_DONE : S_SO_RA;
            end
            REQ_MAX: begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                emit <= 1'b1;
                j <= CW'(1);
                state <= S_RD_WAIT;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_RD_WAIT: state <= (req.req_type == REQ_MAX) ? S_MX_RD : S_MUL;
        S_MX_RD: state <= (j >= count) ? S_MUL : S_MX_CHK;
        S_MX_CHK: begin
          j <= j + 1'b1;
          state <= S_MX_RD;
        end
        S_MUL: state <= S_DONE;
        S_RM_RD: state <= S_RM_CHK;
        S_RM_CHK: begin
          if (sts.id_match) begin
            status <= ST_OK;
            if (more_j) begin
              state <= S_SH_RD;
            end else begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end else if (more_j) begin
            j <= j + 1'b1;
            state <= S_RM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SH_RD: state <= S_SH_LAT;
        S_SH_LAT: state <= S_SH_WR;
        S_SH_WR: begin
          if (j + CW'(2) < count) begin
            j <= j + 1'b1;
            state <= S_SH_RD;
          end else begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_SO_RA: state <= S_SO_RB;
        S_SO_RB: state <= S_SO_LAT;
        S_SO_LAT: state <= S_SO_CMP;
        S_SO_CMP, S_SO_WB: begin
          if (state == S_SO_CMP && sts.a_gt_b) begin
            state <= S_SO_WB;
          end else if (more_j) begin
            j <= j + 1'b1;
            state <= S_SO_RA;
          end else if (more_i) begin
            i <= i + 1'b1;
            j <= i + CW'(2);
            state <= S_SO_RA;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: if (!out_busy) begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/record_table_sort_engine.sv */
// record_table_sort_engine: one response per request, one request in flight at a time;
// max search walks the n held records, remove walks them until the match and then shifts
// the rest down, exchange sort compares every pair and writes both records back per swap,
// all through the one ram read port and one write port
// next request is taken in the cycle the response is raised; rst clears the count
// and control state, stored records are left as they are
module record_table_sort_engine (
  input logic clk,
  input logic rst,
  rts_stream_if.sink req_ch,
  rts_stream_if.source rsp_ch
);
  import rts_pkg::*;

  req_t req;
  cmd_t cmd;
  sts_t sts;
  rec_t best_rec;
  logic [39:0] product;
  logic [CW-1:0] count;
  logic [1:0] status;
  logic emit, done;
  rsp_t rsp;

  rts_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_data(req_ch.data), .req(req), .cmd(cmd), .sts(sts), .count(count), .done(done),
    .status(status), .emit(emit), .out_busy(rsp_ch.valid));

  rts_datapath u_dp (.clk(clk), .req(req), .cmd(cmd), .sts(sts),
    .best_rec(best_rec), .product(product));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_ch.valid <= 1'b0;
    end else if (done) begin
      rsp_ch.valid <= 1'b1;
      rsp <= '{status,
               emit ? best_rec.book_id : 16'd0,
               emit ? best_rec.quantity : 16'd0,
               emit ? best_rec.price : 24'd0,
               emit ? best_rec.title_initial : 8'd0,
               emit ? best_rec.author_initial : 8'd0,
               emit ? product : 40'd0,
               8'(count)};
    end else if (rsp_ch.ready) begin
      rsp_ch.valid <= 1'b0;
    end
  end

  assign rsp_ch.data = rsp;
endmodule

/* verif/tb_record_table_sort_engine.sv */
// testbench for record_table_sort_engine: directed table then random requests,
// each response checked field by field against a directed expected value or the in-bench table predictor
// depends on rts_pkg, rts_stream_if and record_table_sort_engine from the rtl
module tb_record_table_sort_engine;
  import rts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 400000;

  typedef struct {
    req_t req;
    bit typed;
    rsp_t want;
  } row_t;

  logic clk;
  logic rst;

  rts_stream_if #(.W($bits(req_t))) req_ch ();
  rts_stream_if #(.W($bits(rsp_t))) rsp_ch ();

  record_table_sort_engine i_dut (
    .clk(clk),
    .rst(rst),
    .req_ch(req_ch),
    .rsp_ch(rsp_ch)
  );

  rec_t table_q [DEPTH];
  int unsigned held;
  rsp_t expected_rsps [$];
  row_t queued_reqs [$];
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit long_hold;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [23:0] key_of(logic [2:0] kind, rec_t r);
    if (kind == REQ_SORT_TITLE) return {16'd0, r.title_initial};
    if (kind == REQ_SORT_AUTHOR) return {16'd0, r.author_initial};
    return r.price;
  endfunction

  function automatic rsp_t show_rec(rsp_t o, rec_t r);
    o.out_id = r.book_id;
    o.out_quantity = r.quantity;
    o.out_price = r.price;
    o.out_title_initial = r.title_initial;
    o.out_author_initial = r.author_initial;
    o.total_value = 40'(r.price) * 40'(r.quantity);
    return o;
  endfunction

  function automatic rsp_t table_predict(req_t r);
    rsp_t o;
    rec_t t;
    int unsigned best;
    o = '0;
    case (r.req_type)
      REQ_ADD: begin
        if (held >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          table_q[held] = '{r.book_id, r.quantity, r.price_cents, r.title_initial,
                            r.author_initial};
          held++;
        end
      end
      REQ_REMOVE: begin
        o.status = ST_MISSING;
        for (int i = 0; i < held; i++) begin
          if (table_q[i].book_id == r.book_id) begin
            for (int j = i; j + 1 < held; j++) table_q[j] = table_q[j+1];
            held--;
            o.status = ST_OK;
            break;
          end
        end
      end
      REQ_READ: begin
        if (r.slot_index >= held) o.status = ST_MISSING;
        else o = show_rec(o, table_q[r.slot_index]);
      end
      REQ_SORT_TITLE, REQ_SORT_AUTHOR, REQ_SORT_PRICE: begin
        for (int i = 0; i < held; i++) begin
          for (int j = i + 1; j < held; j++) begin
            if (key_of(r.req_type, table_q[i]) > key_of(r.req_type, table_q[j])) begin
              t = table_q[i];
              table_q[i] = table_q[j];
              table_q[j] = t;
            end
          end
        end
      end
      REQ_MAX: begin
        if (held == 0) begin
          o.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held; i++) if (table_q[i].price > table_q[best].price) best = i;
          o = show_rec(o, table_q[best]);
        end
      end
      default: ;
    endcase
    o.entry_count = 8'(held);
    return o;
  endfunction

  task automatic check_rsp(rsp_t got, rsp_t want);
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      fail_cnt++;
    end
    if (got.out_id !== want.out_id) begin
      $error("out_id expected %0h got %0h", want.out_id, got.out_id);
      fail_cnt++;
    end
    if (got.out_quantity !== want.out_quantity) begin
      $error("out_quantity expected %0h got %0h", want.out_quantity, got.out_quantity);
      fail_cnt++;
    end
    if (got.out_price !== want.out_price) begin
      $error("out_price expected %0h got %0h", want.out_price, got.out_price);
      fail_cnt++;
    end
    if (got.out_title_initial !== want.out_title_initial) begin
      $error("out_title_initial expected %0h got %0h", want.out_title_initial,
             got.out_title_initial);
      fail_cnt++;
    end
    if (got.out_author_initial !== want.out_author_initial) begin
      $error("out_author_initial expected %0h got %0h", want.out_author_initial,
             got.out_author_initial);
      fail_cnt++;
    end
    if (got.total_value !== want.total_value) begin
      $error("total_value expected %0h got %0h", want.total_value, got.total_value);
      fail_cnt++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count expected %0d got %0d", want.entry_count, got.entry_count);
      fail_cnt++;
    end
  endtask

  // request acceptance, response check and watchdog
  always @(posedge clk) begin
    rsp_t p;
    row_t w;
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req_ch.valid && req_ch.ready) begin
        w = queued_reqs.pop_front();
        p = table_predict(req_t'(req_ch.data));
        expected_rsps.push_back(w.typed ? w.want : p);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          check_rsp(rsp_t'(rsp_ch.data), expected_rsps.pop_front());
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("record_table_sort_engine verification failed");
        $finish;
      end
    end
  end

  // response side stalls, with one long hold-off on request
  initial begin
    int unsigned mode;
    rsp_ch.ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  task automatic send(req_t r, bit typed = 0, rsp_t want = '0);
    row_t w;
    w.req = r;
    w.typed = typed;
    w.want = want;
    queued_reqs.push_back(w);
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  function automatic req_t mk(logic [2:0] kind, logic [15:0] id = 0, logic [15:0] qty = 0,
                              logic [23:0] price = 0, logic [7:0] ti = 0,
                              logic [7:0] au = 0, logic [6:0] slot = 0);
    return '{kind, id, qty, price, ti, au, slot};
  endfunction

  function automatic req_t rand_req();
    req_t r;
    logic [95:0] raw;
    int unsigned pick;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 5) r.req_type = REQ_UNDEF;
    else if (pick < 45) r.req_type = (held > 40) ? REQ_REMOVE : REQ_ADD;
    else if (pick < 60) r.req_type = REQ_REMOVE;
    else if (pick < 78) r.req_type = REQ_READ;
    else if (pick < 92) r.req_type = 3'($urandom_range(REQ_SORT_TITLE, REQ_SORT_PRICE));
    else r.req_type = REQ_MAX;
    if ($urandom_range(0, 9) < 7) r.book_id = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 7 && held > 0) r.slot_index = 7'($urandom_range(0, held - 1));
    if ($urandom_range(0, 1) == 0) begin
      r.title_initial = 8'($urandom_range(65, 70));
      r.author_initial = 8'($urandom_range(65, 70));
      r.price_cents = 24'($urandom_range(0, 7));
    end
    return r;
  endfunction

  initial begin
    row_t rows [$];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    held = 0;
    fail_cnt = 0;
    idle_cycles = 0;
    burst_left = 0;
    long_hold = 1'b0;

    rows.push_back('{mk(REQ_MAX), 1, rsp_t'({ST_EMPTY, 120'd0})});
    rows.push_back('{mk(REQ_READ), 1, rsp_t'({ST_MISSING, 120'd0})});
    rows.push_back('{mk(REQ_REMOVE, 16'h1234), 1, rsp_t'({ST_MISSING, 120'd0})});
    rows.push_back('{mk(REQ_SORT_PRICE), 1, rsp_t'({ST_OK, 120'd0})});
    rows.push_back('{mk(REQ_UNDEF), 1, rsp_t'({ST_OK, 120'd0})});
    rows.push_back('{mk(REQ_ADD, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF), 1,
                     rsp_t'({ST_OK, 112'd0, 8'd1})});
    rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 7'd0), 1,
                     rsp_t'({ST_OK, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF,
                             40'hFFFFFF * 40'hFFFF, 8'd1})});
    rows.push_back('{mk(REQ_SORT_TITLE), 0, '0});
    rows.push_back('{mk(REQ_ADD), 1, rsp_t'({ST_OK, 112'd0, 8'd2})});
    rows.push_back('{mk(REQ_ADD, 16'h0005, 16'd3, 24'hFFFFFF, 8'h41, 8'h5A), 0, '0});
    rows.push_back('{mk(REQ_MAX), 0, '0});
    rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 7'd127), 1,
                     rsp_t'({ST_MISSING, 112'd0, 8'd3})});
    rows.push_back('{mk(REQ_SORT_TITLE), 0, '0});
    rows.push_back('{mk(REQ_SORT_AUTHOR), 0, '0});
    rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 7'd0), 0, '0});
    rows.push_back('{mk(REQ_SORT_PRICE), 0, '0});
    rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 7'd2), 0, '0});
    rows.push_back('{mk(REQ_REMOVE, 16'hFFFF), 0, '0});
    rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 7'd1), 0, '0});
    rows.push_back('{mk(REQ_REMOVE, 16'h0000), 0, '0});
    rows.push_back('{mk(REQ_REMOVE, 16'h0005), 1, rsp_t'({ST_OK, 120'd0})});
    rows.push_back('{mk(REQ_SORT_AUTHOR), 1, rsp_t'({ST_OK, 120'd0})});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) send(rows[k].req, rows[k].typed, rows[k].want);

    for (int n = 0; n < 75; n++) begin
      if (n == 30) long_hold = 1'b1;
      send(rand_req());
    end

    send(mk(REQ_MAX));
    send(mk(REQ_SORT_PRICE));
    send(mk(REQ_READ, 0, 0, 0, 0, 0, 7'd0));
    send(mk(REQ_READ, 0, 0, 0, 0, 0, 7'd127));

    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0 || queued_reqs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("record_table_sort_engine verification clean");
    end else begin
      $display("record_table_sort_engine verification failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/rts_pkg.sv
hw/rtl/rts_stream_if.sv
hw/rtl/rts_ram.sv
hw/rtl/rts_datapath.sv
hw/rtl/rts_ctrl.sv
hw/rtl/record_table_sort_engine.sv
verif/tb_record_table_sort_engine.sv
